// ===== rtl/grid_mesh_smooth_vertex_normals_defines.svh =====
// Assertion helpers for the top RTL file, which checks its own logic.
`ifndef GRID_MESH_SMOOTH_VERTEX_NORMALS_DEFINES_SVH
`define GRID_MESH_SMOOTH_VERTEX_NORMALS_DEFINES_SVH

// Condition and consequence in the same cycle.
`define GMSVN_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Consequence in the cycle after the condition.
`define GMSVN_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/gmsvn_pkg.sv =====
package gmsvn_pkg;

  localparam int MAX_THETA_DEF = 64;
  localparam int MAX_PHI_DEF   = 64;
  // Point indices never exceed 127 * 127, whatever the grid limits.
  localparam int IW    = 14;
  localparam int ACC_W = 38;

  localparam logic [6:0] THETA_RST = 7'd2;
  localparam logic [6:0] PHI_RST   = 7'd1;

  localparam logic CFG_THETA = 1'b0;
  localparam logic CFG_PHI   = 1'b1;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_COMPUTE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_GRID  = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
  localparam logic [1:0] STAT_NOT_READY = 2'd3;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_CORNER = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [11:0]        point_index;
    logic [12:0]        tri_index;
    logic [1:0]         corner;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         color_r;
    logic [7:0]         color_g;
    logic [7:0]         color_b;
  } in_t;

  typedef struct packed {
    logic               out_kind;
    logic [1:0]         status;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [7:0]         vert_r;
    logic [7:0]         vert_g;
    logic [7:0]         vert_b;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } pt_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } acc_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } nrm_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_DIV, ST_RD_ADDR, ST_RD_DATA, ST_CLEAR, ST_FC_LD, ST_FC_CAP,
    ST_FC_EDGE, ST_FC_MUL, ST_AC_RD, ST_AC_WR, ST_NM_RD, ST_NM_LD, ST_NM_WAIT,
    ST_NM_WR, ST_PUSH
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DIVGO, N_DIVWAIT, N_DONE
  } norm_state_t;

endpackage

// ===== rtl/grid_mesh_smooth_vertex_normals.sv =====
// Channel  Direction  Payload  Handshake
// in       input      in_t     in_valid / in_ready
// out      output     out_t    out_valid / out_ready
// cfg      input      7 bits   cfg_we, cfg_index, cfg_wdata
//
// A corner read waits on the 12-step cell divider. A compute clears the accumulator
// of every point, adds each triangle's face normal into its three corners and then
// normalizes each vertex sum with the bit-serial square root and the 47-step divider
// of the normalizer; a zero sum skips both. One request is in work at a time; a
// result waits in the output register while the next request is taken. Reset is
// synchronous; the stores need no clearing pass.
`include "grid_mesh_smooth_vertex_normals_defines.svh"

module grid_mesh_smooth_vertex_normals
  import gmsvn_pkg::*;
#(
  parameter int MAX_THETA = MAX_THETA_DEF,
  parameter int MAX_PHI   = MAX_PHI_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int NPTS = MAX_THETA * MAX_PHI;
  localparam int AW   = $clog2(NPTS);

  top_state_t state_r, state_nxt;

  logic [6:0]  theta_r;
  logic [6:0]  phi_r;
  logic        ready_r, ready_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r;
  out_t        res_r;

  logic [12:0] ti_r;
  logic [1:0]  corner_r;
  logic [IW-1:0] p_r;
  logic [1:0]  k_r;
  logic [1:0]  comp_r;
  logic [6:0]  t_r;
  logic [6:0]  r_r;
  logic [IW-1:0] base_r_r;
  logic [IW-1:0] base_rn_r;
  logic        face_r;
  logic signed [15:0] pos_r [3][3];
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [34:0] f_r [3];

  // Memories.
  pt_t  pt_mem  [NPTS];
  acc_t acc_mem [NPTS];
  nrm_t nrm_mem [NPTS];
  pt_t  pm_rdata_r;
  acc_t am_rdata_r;
  nrm_t nm_rdata_r;

  logic          pm_we;
  logic [AW-1:0] pm_waddr;
  logic [AW-1:0] pm_raddr;
  logic          am_we;
  logic [AW-1:0] am_waddr;
  acc_t          am_wdata;
  logic [AW-1:0] am_raddr;
  logic          nm_we;
  logic [AW-1:0] nm_raddr;

  logic          in_acc;
  logic          out_load;
  logic [IW-1:0] npts;
  logic          grid_ok;
  logic          wr_ok;
  logic [IW-1:0] ring_tris;
  logic          tri_bad;
  logic [1:0]    rd_status;
  logic          p_last;
  logic          last_t;
  logic          last_r;
  logic          last_face;
  logic [IW-1:0] fp0, fp1, fp2, fp3;
  logic [IW-1:0] corner_p;
  logic          rd_div_start;
  logic          rd_div_done;
  logic [11:0]   rd_quo;
  logic [6:0]    rd_rem;
  logic [6:0]    rd_r;
  logic [6:0]    rd_rn;
  logic [IW-1:0] rd_base;
  logic [IW-1:0] rd_base_n;
  logic [IW-1:0] rd_p;
  logic          nrm_start;
  logic          nrm_done;
  nrm_t          nrm_res;
  logic signed [16:0] ma, mb, mc, md;
  logic signed [33:0] prod_a, prod_b;
  logic signed [34:0] f_new;

  assign in_acc    = in_valid && in_ready;
  assign npts      = IW'(theta_r) * IW'(phi_r);
  assign grid_ok   = (32'(theta_r) >= 2) && (32'(theta_r) <= MAX_THETA) &&
                     (32'(phi_r) >= 1) && (32'(phi_r) <= MAX_PHI);
  assign wr_ok     = grid_ok && (IW'(in_data.point_index) < npts);
  assign ring_tris = IW'(phi_r) * IW'(theta_r - 7'd1);
  assign tri_bad   = (15'(in_data.tri_index) >= {ring_tris, 1'b0}) ||
                     (in_data.corner > 2'd2);

  always_comb begin
    if (!grid_ok) rd_status = STAT_BAD_GRID;
    else if (tri_bad) rd_status = STAT_BAD_INDEX;
    else if (!ready_r) rd_status = STAT_NOT_READY;
    else rd_status = STAT_OK;
  end

  assign p_last    = (p_r == npts - IW'(1));
  assign last_t    = (t_r == theta_r - 7'd2);
  assign last_r    = (r_r == phi_r - 7'd1);
  assign last_face = face_r && last_t && last_r;

  // Corners of the current cell; triangle A uses p0,p1,p2 and B uses p0,p2,p3.
  assign fp0 = IW'(t_r) + base_r_r;
  assign fp1 = IW'(t_r) + base_rn_r;
  assign fp2 = fp1 + IW'(1);
  assign fp3 = fp0 + IW'(1);

  always_comb begin
    case (k_r)
      2'd0:    corner_p = fp0;
      2'd1:    corner_p = face_r ? fp2 : fp1;
      default: corner_p = face_r ? fp3 : fp2;
    endcase
  end

  // Corner address of a read request from the cell's ring and theta position.
  gmsvn_div #(.NW(12), .DW(7)) u_cell_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rd_div_start),
    .num   (in_data.tri_index[12:1]),
    .den   (theta_r - 7'd1),
    .done  (rd_div_done),
    .quo   (rd_quo),
    .rem   (rd_rem)
  );

  assign rd_r      = rd_quo[6:0];
  assign rd_rn     = (rd_r + 7'd1 == phi_r) ? 7'd0 : rd_r + 7'd1;
  assign rd_base   = IW'(rd_r) * IW'(theta_r);
  assign rd_base_n = IW'(rd_rn) * IW'(theta_r);

  always_comb begin
    if (corner_r == 2'd0) rd_p = IW'(rd_rem) + rd_base;
    else if (!ti_r[0] && corner_r == 2'd1) rd_p = IW'(rd_rem) + rd_base_n;
    else if (!ti_r[0] || corner_r == 2'd1) rd_p = IW'(rd_rem) + rd_base_n + IW'(1);
    else rd_p = IW'(rd_rem) + rd_base + IW'(1);
  end

  // One component of the face normal per cycle.
  always_comb begin
    case (comp_r)
      2'd0: begin
        ma = e1_r[1]; mb = e2_r[2]; mc = e1_r[2]; md = e2_r[1];
      end
      2'd1: begin
        ma = e1_r[2]; mb = e2_r[0]; mc = e1_r[0]; md = e2_r[2];
      end
      default: begin
        ma = e1_r[0]; mb = e2_r[1]; mc = e1_r[1]; md = e2_r[0];
      end
    endcase
  end

  assign prod_a = ma * mb;
  assign prod_b = mc * md;
  assign f_new  = 35'(prod_a) - 35'(prod_b);

  gmsvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nrm_start),
    .acc   (am_rdata_r),
    .done  (nrm_done),
    .nrm   (nrm_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_COMPUTE) begin
            state_nxt = grid_ok ? ST_CLEAR : ST_PUSH;
          end else if (in_data.req_type == REQ_READ) begin
            state_nxt = (rd_status == STAT_OK) ? ST_RD_DIV : ST_PUSH;
          end
        end
      end
      ST_RD_DIV:  if (rd_div_done) state_nxt = ST_RD_ADDR;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_PUSH;
      ST_CLEAR:   if (p_last) state_nxt = ST_FC_LD;
      ST_FC_LD:   state_nxt = ST_FC_CAP;
      ST_FC_CAP:  state_nxt = (k_r == 2'd2) ? ST_FC_EDGE : ST_FC_LD;
      ST_FC_EDGE: state_nxt = ST_FC_MUL;
      ST_FC_MUL:  if (comp_r == 2'd2) state_nxt = ST_AC_RD;
      ST_AC_RD:   state_nxt = ST_AC_WR;
      ST_AC_WR: begin
        if (k_r != 2'd2) state_nxt = ST_AC_RD;
        else state_nxt = last_face ? ST_NM_RD : ST_FC_LD;
      end
      ST_NM_RD:   state_nxt = ST_NM_LD;
      ST_NM_LD:   state_nxt = ST_NM_WAIT;
      ST_NM_WAIT: if (nrm_done) state_nxt = ST_NM_WR;
      ST_NM_WR:   state_nxt = p_last ? ST_PUSH : ST_NM_RD;
      ST_PUSH:    if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    rd_div_start = 1'b0;
    pm_we        = 1'b0;
    pm_waddr     = AW'(in_data.point_index);
    pm_raddr     = AW'(rd_p);
    am_we        = 1'b0;
    am_waddr     = AW'(p_r);
    am_wdata     = '0;
    am_raddr     = AW'(p_r);
    nm_we        = 1'b0;
    nm_raddr     = AW'(rd_p);
    nrm_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        pm_we        = in_acc && (in_data.req_type == REQ_WRITE) && wr_ok;
        rd_div_start = in_acc && (in_data.req_type == REQ_READ) && (rd_status == STAT_OK);
      end
      ST_CLEAR: am_we = 1'b1;
      ST_FC_LD: pm_raddr = AW'(corner_p);
      ST_AC_RD: am_raddr = AW'(corner_p);
      ST_AC_WR: begin
        am_we      = 1'b1;
        am_waddr   = AW'(corner_p);
        am_wdata.x = am_rdata_r.x + ACC_W'(f_r[0]);
        am_wdata.y = am_rdata_r.y + ACC_W'(f_r[1]);
        am_wdata.z = am_rdata_r.z + ACC_W'(f_r[2]);
      end
      ST_NM_LD: nrm_start = 1'b1;
      ST_NM_WR: nm_we = 1'b1;
      ST_PUSH:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    ready_nxt = ready_r;
    if (cfg_we || pm_we) ready_nxt = 1'b0;
    else if (state_r == ST_NM_WR && p_last) ready_nxt = 1'b1;
  end

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      theta_r     <= THETA_RST;
      phi_r       <= PHI_RST;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THETA: theta_r <= cfg_wdata;
          CFG_PHI:   phi_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pt_mem[pm_waddr] <= '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
                            r: in_data.color_r, g: in_data.color_g, b: in_data.color_b};
    end
    pm_rdata_r <= pt_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) acc_mem[am_waddr] <= am_wdata;
    am_rdata_r <= acc_mem[am_raddr];
  end

  always_ff @(posedge clk) begin
    if (nm_we) nrm_mem[AW'(p_r)] <= nrm_res;
    nm_rdata_r <= nrm_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ti_r      <= in_data.tri_index;
          corner_r  <= in_data.corner;
          p_r       <= '0;
          k_r       <= 2'd0;
          comp_r    <= 2'd0;
          t_r       <= 7'd0;
          r_r       <= 7'd0;
          face_r    <= 1'b0;
          base_r_r  <= '0;
          base_rn_r <= (phi_r == 7'd1) ? '0 : IW'(theta_r);
          res_r     <= '{out_kind: (in_data.req_type == REQ_COMPUTE) ? KIND_ACK : KIND_CORNER,
                         status: (in_data.req_type == REQ_COMPUTE) ? STAT_BAD_GRID : rd_status,
                         default: '0};
        end
      end
      ST_RD_DATA: begin
        res_r.out_kind <= KIND_CORNER;
        res_r.status   <= STAT_OK;
        res_r.vert_x   <= pm_rdata_r.x;
        res_r.vert_y   <= pm_rdata_r.y;
        res_r.vert_z   <= pm_rdata_r.z;
        res_r.norm_x   <= nm_rdata_r.x;
        res_r.norm_y   <= nm_rdata_r.y;
        res_r.norm_z   <= nm_rdata_r.z;
        res_r.vert_r   <= pm_rdata_r.r;
        res_r.vert_g   <= pm_rdata_r.g;
        res_r.vert_b   <= pm_rdata_r.b;
      end
      ST_CLEAR: p_r <= p_last ? '0 : p_r + IW'(1);
      ST_FC_CAP: begin
        pos_r[k_r][0] <= pm_rdata_r.x;
        pos_r[k_r][1] <= pm_rdata_r.y;
        pos_r[k_r][2] <= pm_rdata_r.z;
        k_r           <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_FC_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= 17'(pos_r[1][i]) - 17'(pos_r[0][i]);
          e2_r[i] <= 17'(pos_r[2][i]) - 17'(pos_r[0][i]);
        end
      end
      ST_FC_MUL: begin
        f_r[comp_r] <= f_new;
        comp_r      <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      end
      ST_AC_WR: begin
        k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        if (k_r == 2'd2) begin
          if (!face_r) begin
            face_r <= 1'b1;
          end else begin
            face_r <= 1'b0;
            if (last_t) begin
              t_r       <= 7'd0;
              r_r       <= r_r + 7'd1;
              base_r_r  <= base_r_r + IW'(theta_r);
              // The ring after next wraps to ring zero.
              base_rn_r <= (r_r + 7'd2 == phi_r) ? '0 : base_rn_r + IW'(theta_r);
            end else begin
              t_r <= t_r + 7'd1;
            end
          end
        end
      end
      ST_NM_WR: begin
        p_r <= p_last ? '0 : p_r + IW'(1);
        if (p_last) begin
          res_r <= '{out_kind: KIND_ACK, status: STAT_OK, default: '0};
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GMSVN_ASSERT_NEXT(a_cfg_clears_ready, cfg_we, !ready_r)
  `GMSVN_ASSERT_NOW(a_div_done_in_read, rd_div_done, state_r == ST_RD_DIV)
  `GMSVN_ASSERT_NOW(a_norm_done_in_wait, nrm_done, state_r == ST_NM_WAIT)
  `GMSVN_ASSERT_NEXT(a_push_loads, (state_r == ST_PUSH) && out_ready, out_valid_r)

endmodule

// ===== rtl/gmsvn_div.sv =====
module gmsvn_div
  import gmsvn_pkg::*;
#(
  parameter int NW = 12,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = !diff[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(NW);
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/gmsvn_norm.sv =====
module gmsvn_norm
  import gmsvn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  acc_t acc,
  output logic done,
  output nrm_t nrm
);

  localparam int SUM_W = 50;
  localparam int RT_W  = 62;
  localparam int DN_W  = 47;
  localparam int DD_W  = 32;

  norm_state_t state_r, state_nxt;

  logic [ACC_W-1:0]   mag_r [3];
  logic [2:0]         neg_r;
  logic [ACC_W-1:0]   max_r;
  logic [1:0]         idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RT_W-1:0]    n_r;
  logic [RT_W-1:0]    root_r;
  logic [RT_W-1:0]    bit_r;
  logic [4:0]         step_r;
  logic signed [15:0] res_r [3];

  logic [47:0]        sq;
  logic [SUM_W-1:0]   sum_add;
  logic [RT_W-1:0]    rt_trial;
  logic               rt_ge;
  logic [ACC_W-1:0]   max3;
  logic               dv_start;
  logic               dv_done;
  logic [DN_W-1:0]    dv_num;
  logic [DD_W-1:0]    dv_den;
  logic [DN_W-1:0]    dv_quo;
  logic signed [15:0] sat;

  function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] a);
    return a[ACC_W-1] ? (ACC_W'(0) - a) : a;
  endfunction

  assign sq       = mag_r[idx_r][23:0] * mag_r[idx_r][23:0];
  assign sum_add  = sum_r + SUM_W'(sq);
  assign rt_trial = root_r + bit_r;
  assign rt_ge    = n_r >= rt_trial;
  assign dv_num   = DN_W'({mag_r[idx_r][23:0], 22'b0}) + DN_W'(root_r[30:0]);
  assign dv_den   = {root_r[30:0], 1'b0};

  always_comb begin
    max3 = mag_r[0];
    if (mag_r[1] > max3) max3 = mag_r[1];
    if (mag_r[2] > max3) max3 = mag_r[2];
  end

  // Round-half-away quotient, sign put back, clipped to Q1.15.
  always_comb begin
    if (neg_r[idx_r]) begin
      sat = (dv_quo > DN_W'(32768)) ? 16'sh8000 : 16'(16'd0 - dv_quo[15:0]);
    end else begin
      sat = (dv_quo > DN_W'(32767)) ? 16'sh7fff : 16'(dv_quo[15:0]);
    end
  end

  gmsvn_div #(.NW(DN_W), .DW(DD_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo),
    .rem   ()
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:    if (start) state_nxt = N_MAX;
      N_MAX:     state_nxt = N_SHIFT;
      N_SHIFT: begin
        if (max_r == '0) state_nxt = N_DONE;
        else if (max_r[ACC_W-1:24] == '0) state_nxt = N_SQ;
      end
      N_SQ:      if (idx_r == 2'd2) state_nxt = N_SQRT;
      N_SQRT:    if (step_r == '0) state_nxt = N_DIVGO;
      N_DIVGO:   state_nxt = N_DIVWAIT;
      N_DIVWAIT: if (dv_done) state_nxt = (idx_r == 2'd2) ? N_DONE : N_DIVGO;
      N_DONE:    state_nxt = N_IDLE;
      default:   state_nxt = N_IDLE;
    endcase
  end

  always_comb begin
    dv_start = 1'b0;
    done     = 1'b0;
    unique case (state_r)
      N_DIVGO: dv_start = 1'b1;
      N_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= N_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (start) begin
          mag_r[0] <= mag_of(acc.x);
          mag_r[1] <= mag_of(acc.y);
          mag_r[2] <= mag_of(acc.z);
          neg_r    <= {acc.z[ACC_W-1], acc.y[ACC_W-1], acc.x[ACC_W-1]};
        end
      end
      N_MAX: max_r <= max3;
      N_SHIFT: begin
        if (max_r == '0) begin
          res_r[0] <= '0;
          res_r[1] <= '0;
          res_r[2] <= '0;
        end else if (max_r[ACC_W-1:24] != '0) begin
          // Shifting one bit at a time gives the same truncation as one wide shift.
          max_r    <= max_r >> 1;
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else begin
          sum_r <= '0;
          idx_r <= 2'd0;
        end
      end
      N_SQ: begin
        sum_r <= sum_add;
        if (idx_r == 2'd2) begin
          idx_r  <= 2'd0;
          n_r    <= {sum_add, 12'b0};
          root_r <= '0;
          bit_r  <= RT_W'(1) << 60;
          step_r <= 5'd30;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      N_SQRT: begin
        if (rt_ge) begin
          n_r    <= n_r - rt_trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r - 5'd1;
      end
      N_DIVWAIT: begin
        if (dv_done) begin
          res_r[idx_r] <= sat;
          idx_r        <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign nrm.x = res_r[0];
  assign nrm.y = res_r[1];
  assign nrm.z = res_r[2];

endmodule
